// ===== rtl/bce_pkg.sv =====
package bce_pkg;

    localparam int COORD_W  = 32;
    localparam int POS_W    = 17;
    localparam int SLOT_W   = 4;
    localparam int CFG_W    = 5;
    localparam int COEF_W   = 13;
    localparam int POW_W    = 17;
    localparam int PAIR_W   = 33;
    localparam int WGT_W    = 31;
    localparam int ACC_W    = 64;
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 33;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int TAB_ROWS = 16;

    localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [0:0] KIND_WRITE = 1'b0;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_POW_T,
        OP_POW_U,
        OP_WPAIR,
        OP_WCOEF,
        OP_PX,
        OP_PY,
        OP_PZ
    } op_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef logic [TAB_ROWS-1:0][TAB_ROWS-1:0][COEF_W-1:0] binom_tab_t;

    // Pascal's triangle, row r holds C(r, k); built at elaboration
    function automatic binom_tab_t build_binom();
        binom_tab_t tab;
        logic [TAB_ROWS-1:0][COEF_W-1:0] row;
        int r;
        int k;
        tab = '0;
        row = '0;
        row[0] = COEF_W'(1);
        for (r = 0; r < TAB_ROWS; r++)
        begin
            for (k = TAB_ROWS - 1; k > 0; k--)
            begin
                if (k <= r)
                begin
                    row[k] = row[k] + row[k-1];
                end
            end
            tab[r] = row;
        end
        return tab;
    endfunction

    localparam binom_tab_t BINOM = build_binom();

endpackage

// ===== rtl/bce_stream_if.sv =====
interface bce_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [bce_pkg::SLOT_W-1:0]            point_index;
    logic signed [bce_pkg::COORD_W-1:0]    x_in;
    logic signed [bce_pkg::COORD_W-1:0]    y_in;
    logic signed [bce_pkg::COORD_W-1:0]    z_in;
    logic [bce_pkg::POS_W-1:0]             position;

    modport source (output valid, kind, point_index, x_in, y_in, z_in, position,
                    input ready);
    modport sink (input valid, kind, point_index, x_in, y_in, z_in, position,
                  output ready);
endinterface

interface bce_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bce_pkg::COORD_W-1:0]    x_out;
    logic signed [bce_pkg::COORD_W-1:0]    y_out;
    logic signed [bce_pkg::COORD_W-1:0]    z_out;

    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink (input valid, x_out, y_out, z_out, output ready);
endinterface

// ===== rtl/bce_mul.sv =====
// shared signed multiplier, product registered
module bce_mul
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [bce_pkg::MUL_A_W-1:0]     a,
    input  logic signed [bce_pkg::MUL_B_W-1:0]     b,
    output logic signed [bce_pkg::MUL_P_W-1:0]     p
);

    logic signed [bce_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= bce_pkg::MUL_P_W'(a) * bce_pkg::MUL_P_W'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/bce_point_store.sv =====
// control point store, x/y/z per slot, cleared by reset
module bce_point_store #(
    parameter int MAX_POINTS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [bce_pkg::SLOT_W-1:0]         waddr,
    input  bce_pkg::point_t                    wdata,
    input  logic [$clog2(MAX_POINTS)-1:0]      raddr,
    output bce_pkg::point_t                    rdata
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    bce_pkg::point_t store_reg [MAX_POINTS];
    logic            slot_ok;

    // slots at or above MAX_POINTS are dropped
    assign slot_ok = ({1'b0, waddr} < (bce_pkg::SLOT_W + 1)'(MAX_POINTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_POINTS; s++)
            begin
                store_reg[s] <= '0;
            end
        end
        else if (we && slot_ok)
        begin
            store_reg[waddr[IDX_W-1:0]] <= wdata;
        end
    end

    assign rdata = store_reg[raddr];

endmodule

// ===== rtl/bezier_curve_evaluator_core.sv =====
// Bezier curve evaluator, Bernstein form, 3D Q16.16, one shared multiplier.
// Write request: stored when accepted; a new request is taken in the next cycle.
// Evaluate request, n active points: 2*(n-1) power steps plus 5 multiplies per point,
// each an issue then a write-back state; n = 0 goes straight to the result.
// No new request is taken until the result is registered; a held result stalls that.
// Reset (rst_n, async low): point store zero, point count 4, no result pending.
module bezier_curve_evaluator_core #(
    parameter int MAX_POINTS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bce_pkg::CFG_W-1:0]          cfg_wdata,
    bce_req_if.sink                            request,
    bce_rsp_if.source                          result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int RESET_COUNT = (MAX_POINTS < 4) ? MAX_POINTS : 4;

    // sequencer state
    bce_pkg::state_t state_reg, state_next;
    bce_pkg::op_t    op_reg, op_next;

    // active point count, already clamped to MAX_POINTS
    logic [CNT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0] n_m1;

    logic [bce_pkg::POW_W-1:0] t_reg, t_next;
    logic [bce_pkg::POW_W-1:0] u_reg, u_next;
    logic [bce_pkg::POW_W-1:0] tcur_reg, tcur_next;
    logic [bce_pkg::POW_W-1:0] ucur_reg, ucur_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_idx;
    logic [bce_pkg::PAIR_W-1:0] pair_reg, pair_next;
    logic [bce_pkg::WGT_W-1:0]  w_reg, w_next;
    logic signed [bce_pkg::ACC_W-1:0] ax_reg, ax_next;
    logic signed [bce_pkg::ACC_W-1:0] ay_reg, ay_next;
    logic signed [bce_pkg::ACC_W-1:0] az_reg, az_next;

    // powers t^k and (1-t)^k
    logic [bce_pkg::POW_W-1:0] tpow_reg [MAX_POINTS];
    logic [bce_pkg::POW_W-1:0] upow_reg [MAX_POINTS];
    logic pow_init;
    logic tpow_we;
    logic upow_we;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic signed [bce_pkg::COORD_W-1:0] x_out_reg, x_out_next;
    logic signed [bce_pkg::COORD_W-1:0] y_out_reg, y_out_next;
    logic signed [bce_pkg::COORD_W-1:0] z_out_reg, z_out_next;

    // shared multiplier
    logic signed [bce_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bce_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bce_pkg::MUL_P_W-1:0] mul_p;
    logic                               mul_en;
    logic [47:0]                        rnd_sum;
    logic [bce_pkg::POW_W-1:0]          pow_rnd;
    logic [bce_pkg::WGT_W-1:0]          w_rnd;
    logic signed [bce_pkg::ACC_W-1:0]   term;

    logic [bce_pkg::COEF_W-1:0] coef;
    logic [bce_pkg::POS_W-1:0]  t_clamp;
    logic                       store_we;
    bce_pkg::point_t            wr_point;
    bce_pkg::point_t            rd_point;

    // Q16.32 sum -> Q16.16: add half, floor shift, saturate to 32 bits
    function automatic logic signed [bce_pkg::COORD_W-1:0] round_sat(
        input logic signed [bce_pkg::ACC_W-1:0] acc);
        logic signed [bce_pkg::ACC_W:0] s;
        logic [48:0] q;
        s = (bce_pkg::ACC_W + 1)'(acc) + (bce_pkg::ACC_W + 1)'(32768);
        q = s[bce_pkg::ACC_W:16];
        if (q[48:31] == '0 || q[48:31] == '1)
        begin
            return q[31:0];
        end
        else if (q[48])
        begin
            return bce_pkg::COORD_MIN;
        end
        else
        begin
            return bce_pkg::COORD_MAX;
        end
    endfunction

    bce_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign wr_point.x = request.x_in;
    assign wr_point.y = request.y_in;
    assign wr_point.z = request.z_in;

    bce_point_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (store_we),
        .waddr (request.point_index),
        .wdata (wr_point),
        .raddr (i_reg),
        .rdata (rd_point)
    );

    assign n_m1    = CNT_W'(active_reg - CNT_W'(1));
    assign j_idx   = IDX_W'(n_m1 - CNT_W'(i_reg));
    assign coef    = bce_pkg::BINOM[4'(n_m1)][4'(i_reg)];
    assign t_clamp = (request.position > bce_pkg::ONE_Q16) ? bce_pkg::ONE_Q16
                                                           : request.position;

    // product taps: round half up for powers and weights, full term for coords
    assign rnd_sum = 48'(mul_p[47:0]) + 48'd32768;
    assign pow_rnd = rnd_sum[32:16];
    assign w_rnd   = rnd_sum[46:16];
    assign term    = mul_p[bce_pkg::ACC_W-1:0];

    assign mul_en        = (state_reg == bce_pkg::ST_ISSUE);
    assign request.ready = (state_reg == bce_pkg::ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.x_out  = x_out_reg;
    assign result.y_out  = y_out_reg;
    assign result.z_out  = z_out_reg;

    // operand select for the op in flight
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            bce_pkg::OP_POW_T:
            begin
                mul_a = bce_pkg::MUL_A_W'(tcur_reg);
                mul_b = bce_pkg::MUL_B_W'(t_reg);
            end
            bce_pkg::OP_POW_U:
            begin
                mul_a = bce_pkg::MUL_A_W'(ucur_reg);
                mul_b = bce_pkg::MUL_B_W'(u_reg);
            end
            bce_pkg::OP_WPAIR:
            begin
                mul_a = bce_pkg::MUL_A_W'(tpow_reg[i_reg]);
                mul_b = bce_pkg::MUL_B_W'(upow_reg[j_idx]);
            end
            bce_pkg::OP_WCOEF:
            begin
                mul_a = bce_pkg::MUL_A_W'(pair_reg);
                mul_b = bce_pkg::MUL_B_W'(coef);
            end
            bce_pkg::OP_PX:
            begin
                mul_a = bce_pkg::MUL_A_W'(w_reg);
                mul_b = bce_pkg::MUL_B_W'(rd_point.x);
            end
            bce_pkg::OP_PY:
            begin
                mul_a = bce_pkg::MUL_A_W'(w_reg);
                mul_b = bce_pkg::MUL_B_W'(rd_point.y);
            end
            bce_pkg::OP_PZ:
            begin
                mul_a = bce_pkg::MUL_A_W'(w_reg);
                mul_b = bce_pkg::MUL_B_W'(rd_point.z);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        active_next    = active_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        tcur_next      = tcur_reg;
        ucur_next      = ucur_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        pair_next      = pair_reg;
        w_next         = w_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        out_valid_next = out_valid_reg;
        x_out_next     = x_out_reg;
        y_out_next     = y_out_reg;
        z_out_next     = z_out_reg;
        pow_init       = 1'b0;
        tpow_we        = 1'b0;
        upow_we        = 1'b0;
        store_we       = 1'b0;

        // point count write, clamped to MAX_POINTS
        if (cfg_we)
        begin
            if ({1'b0, cfg_wdata} > (bce_pkg::CFG_W + 1)'(MAX_POINTS))
            begin
                active_next = CNT_W'(MAX_POINTS);
            end
            else
            begin
                active_next = CNT_W'(cfg_wdata);
            end
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.kind == bce_pkg::KIND_WRITE)
                    begin
                        store_we = 1'b1;
                    end
                    else
                    begin
                        t_next    = t_clamp;
                        u_next    = bce_pkg::POW_W'(bce_pkg::ONE_Q16 - t_clamp);
                        tcur_next = bce_pkg::ONE_Q16;
                        ucur_next = bce_pkg::ONE_Q16;
                        pow_init  = 1'b1;
                        k_next    = IDX_W'(1);
                        i_next    = '0;
                        ax_next   = '0;
                        ay_next   = '0;
                        az_next   = '0;
                        if (active_reg == '0)
                        begin
                            state_next = bce_pkg::ST_DONE;
                        end
                        else if (active_reg == CNT_W'(1))
                        begin
                            op_next    = bce_pkg::OP_WPAIR;
                            state_next = bce_pkg::ST_ISSUE;
                        end
                        else
                        begin
                            op_next    = bce_pkg::OP_POW_T;
                            state_next = bce_pkg::ST_ISSUE;
                        end
                    end
                end
            end
            bce_pkg::ST_ISSUE:
            begin
                state_next = bce_pkg::ST_WB;
            end
            bce_pkg::ST_WB:
            begin
                state_next = bce_pkg::ST_ISSUE;
                unique case (op_reg)
                    bce_pkg::OP_POW_T:
                    begin
                        tcur_next = pow_rnd;
                        tpow_we   = 1'b1;
                        op_next   = bce_pkg::OP_POW_U;
                    end
                    bce_pkg::OP_POW_U:
                    begin
                        ucur_next = pow_rnd;
                        upow_we   = 1'b1;
                        if (CNT_W'(k_reg) == n_m1)
                        begin
                            op_next = bce_pkg::OP_WPAIR;
                            i_next  = '0;
                        end
                        else
                        begin
                            k_next  = IDX_W'(k_reg + IDX_W'(1));
                            op_next = bce_pkg::OP_POW_T;
                        end
                    end
                    bce_pkg::OP_WPAIR:
                    begin
                        pair_next = mul_p[bce_pkg::PAIR_W-1:0];
                        op_next   = bce_pkg::OP_WCOEF;
                    end
                    bce_pkg::OP_WCOEF:
                    begin
                        w_next  = w_rnd;
                        op_next = bce_pkg::OP_PX;
                    end
                    bce_pkg::OP_PX:
                    begin
                        ax_next = ax_reg + term;
                        op_next = bce_pkg::OP_PY;
                    end
                    bce_pkg::OP_PY:
                    begin
                        ay_next = ay_reg + term;
                        op_next = bce_pkg::OP_PZ;
                    end
                    bce_pkg::OP_PZ:
                    begin
                        az_next = az_reg + term;
                        if (CNT_W'(i_reg) == n_m1)
                        begin
                            state_next = bce_pkg::ST_DONE;
                        end
                        else
                        begin
                            i_next  = IDX_W'(i_reg + IDX_W'(1));
                            op_next = bce_pkg::OP_WPAIR;
                        end
                    end
                    default:
                    begin
                        state_next = bce_pkg::ST_IDLE;
                    end
                endcase
            end
            bce_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    x_out_next     = round_sat(ax_reg);
                    y_out_next     = round_sat(ay_reg);
                    z_out_next     = round_sat(az_reg);
                    state_next     = bce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bce_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bce_pkg::ST_IDLE;
            op_reg        <= bce_pkg::OP_POW_T;
            active_reg    <= CNT_W'(RESET_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        u_reg     <= u_next;
        tcur_reg  <= tcur_next;
        ucur_reg  <= ucur_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        pair_reg  <= pair_next;
        w_reg     <= w_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        x_out_reg <= x_out_next;
        y_out_reg <= y_out_next;
        z_out_reg <= z_out_next;
        if (pow_init)
        begin
            tpow_reg[0] <= bce_pkg::ONE_Q16;
            upow_reg[0] <= bce_pkg::ONE_Q16;
        end
        if (tpow_we)
        begin
            tpow_reg[k_reg] <= pow_rnd;
        end
        if (upow_we)
        begin
            upow_reg[k_reg] <= pow_rnd;
        end
    end

endmodule

// ===== tb/bce_checker.sv =====
module bce_checker
    import bce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    bce_req_if               request,
    bce_rsp_if               result,
    output int               err_count,
    output int               pending,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the block state
    logic signed [COORD_W-1:0] ctrl_x [TAB_ROWS];
    logic signed [COORD_W-1:0] ctrl_y [TAB_ROWS];
    logic signed [COORD_W-1:0] ctrl_z [TAB_ROWS];
    logic [COEF_W-1:0]         coef_row [TAB_ROWS];
    logic [CFG_W-1:0]          count_reg;

    point_t expected_points [$];
    point_t want;

    function automatic int active_count();
        return (count_reg > TAB_ROWS) ? TAB_ROWS : int'(count_reg);
    endfunction

    // binomial row C(n-1, k) by Pascal's rule, truncated to the table width
    function automatic void rebuild_coef_row();
        int row [TAB_ROWS];
        int n;
        int r;
        int k;
        n = active_count();
        for (k = 0; k < TAB_ROWS; k++)
        begin
            row[k] = 0;
            coef_row[k] = '0;
        end
        if (n == 0)
            return;
        row[0] = 1;
        for (r = 1; r < n; r++)
        begin
            for (k = r; k > 0; k--)
                row[k] = row[k] + row[k-1];
        end
        for (k = 0; k < n; k++)
            coef_row[k] = COEF_W'(row[k]);
    endfunction

    function automatic void reset_model();
        int i;
        for (i = 0; i < TAB_ROWS; i++)
        begin
            ctrl_x[i] = '0;
            ctrl_y[i] = '0;
            ctrl_z[i] = '0;
        end
        count_reg = CFG_W'(4);
        rebuild_coef_row();
        expected_points.delete();
        err_count = 0;
        checked = 0;
    endfunction

    // round half up from Q16.32 to Q16.16, then clamp to 32 bits
    function automatic logic signed [COORD_W-1:0] round_sat(longint acc);
        longint q;
        q = (acc + 64'sd32768) >>> 16;
        if (q > longint'(COORD_MAX))
            q = longint'(COORD_MAX);
        if (q < longint'(COORD_MIN))
            q = longint'(COORD_MIN);
        return q[COORD_W-1:0];
    endfunction

    function automatic point_t predict_curve_point(logic [POS_W-1:0] pos);
        longint unsigned t;
        longint unsigned u;
        longint unsigned tp [TAB_ROWS];
        longint unsigned up [TAB_ROWS];
        longint unsigned w;
        longint ax;
        longint ay;
        longint az;
        int n;
        int i;
        point_t p;
        t = 64'(pos);
        if (t > 64'(ONE_Q16))
            t = 64'(ONE_Q16);
        u = 64'(ONE_Q16) - t;
        n = active_count();
        ax = 0;
        ay = 0;
        az = 0;
        if (n > 0)
        begin
            tp[0] = 64'(ONE_Q16);
            up[0] = 64'(ONE_Q16);
            for (i = 1; i < n; i++)
            begin
                tp[i] = (tp[i-1] * t + 64'd32768) >> 16;
                up[i] = (up[i-1] * u + 64'd32768) >> 16;
            end
            for (i = 0; i < n; i++)
            begin
                w = (64'(coef_row[i]) * tp[i] * up[n-1-i] + 64'd32768) >> 16;
                ax += longint'(w) * longint'(ctrl_x[i]);
                ay += longint'(w) * longint'(ctrl_y[i]);
                az += longint'(w) * longint'(ctrl_z[i]);
            end
        end
        p.x = round_sat(ax);
        p.y = round_sat(ay);
        p.z = round_sat(az);
        return p;
    endfunction

    function automatic void check_coord(string name, logic signed [COORD_W-1:0] exp_v,
                                        logic signed [COORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg = cfg_wdata;
                rebuild_coef_row();
            end
            if (result.valid && result.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                             $time, result.x_out, result.y_out, result.z_out);
                end
                else
                begin
                    want = expected_points.pop_front();
                    checked++;
                    check_coord("x_out", want.x, result.x_out);
                    check_coord("y_out", want.y, result.y_out);
                    check_coord("z_out", want.z, result.z_out);
                end
            end
            if (request.valid && request.ready)
            begin
                if (request.kind == KIND_WRITE)
                begin
                    ctrl_x[request.point_index] = request.x_in;
                    ctrl_y[request.point_index] = request.y_in;
                    ctrl_z[request.point_index] = request.z_in;
                end
                else
                begin
                    expected_points.push_back(predict_curve_point(request.position));
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

// ===== tb/bezier_curve_evaluator_core_tb.sv =====
module bezier_curve_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bce_pkg::*;

    localparam logic [0:0] KIND_EVAL = 1'b1;
    // drain margin, longer than the slowest evaluation (16 points)
    localparam int DRAIN_CYCLES = 240;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_REQS   = 80;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    bce_req_if req_ch();
    bce_rsp_if rsp_ch();

    // idle/stall odds in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;

    int cycles = 0;
    int err_count;
    int pending;
    int checked;
    int n_sent  = 0;
    int n_evals = 0;
    int n_cfg   = 0;

    bezier_curve_evaluator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (rsp_ch)
    );

    bce_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (rsp_ch),
        .err_count (err_count),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: drop ready at random per the current stall odds
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
            $display("bezier_curve_evaluator_core_tb: done, errors");
            $finish;
        end
    end

    // Present one request and hold it until accepted. Valid stays high across
    // back-to-back requests; it only drops while the sender is idling.
    task automatic send_request(input logic kind, input logic [SLOT_W-1:0] idx,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.point_index <= idx;
        req_ch.x_in        <= x;
        req_ch.y_in        <= y;
        req_ch.z_in        <= z;
        req_ch.position    <= pos;
        n_sent++;
        if (kind == KIND_EVAL)
            n_evals++;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // write request: position is don't-care, so toggle it freely
    task automatic write_point(input logic [SLOT_W-1:0] idx,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z);
        send_request(KIND_WRITE, idx, x, y, z, POS_W'($urandom_range(0, 2**POS_W - 1)));
    endtask

    // evaluate request: slot and coordinates are don't-care
    task automatic eval_at(input logic [POS_W-1:0] pos);
        send_request(KIND_EVAL, SLOT_W'($urandom_range(0, 2**SLOT_W - 1)),
                     $urandom, $urandom, $urandom, pos);
    endtask

    // Point count is only rewritten with the block idle: stop sending, let all
    // results drain (sampled on the falling edge), wait out the last write request,
    // then pulse the write enable.
    task automatic set_point_count(input logic [CFG_W-1:0] value);
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_cfg++;
    endtask

    // mix of full-range, small and extreme coordinates
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return COORD_W'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // mostly in [0, 1.0]; some exact ends and some above one (clamped)
    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q16;
            2: return POS_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
            default: return POS_W'($urandom_range(0, 32'h1_0000));
        endcase
    endfunction

    initial
    begin
        int count_plan [8];
        int phase;
        int k;

        count_plan = '{16, 3, 31, 1, 7, 12, 2, 16};

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_WRITE;
        req_ch.point_index <= '0;
        req_ch.x_in        <= '0;
        req_ch.y_in        <= '0;
        req_ch.z_in        <= '0;
        req_ch.position    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset point count of four ---
        // empty store gives the origin
        eval_at('0);
        // coordinate extremes in the four active slots
        write_point(SLOT_W'(0), COORD_MAX, COORD_MIN, '0);
        write_point(SLOT_W'(1), COORD_MIN, COORD_MAX, -1);
        write_point(SLOT_W'(2), 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
        write_point(SLOT_W'(3), -1, 1, COORD_MAX);
        // curve ends, midpoint, near-ends, and positions above one
        eval_at('0);
        eval_at(ONE_Q16);
        eval_at(POS_W'(17'h0_8000));
        eval_at(POS_W'(17'h1_FFFF));
        eval_at(POS_W'(17'h1_0001));
        eval_at(POS_W'(1));
        eval_at(POS_W'(ONE_Q16 - 1));
        // slot beyond the point count is stored but must not contribute
        write_point(SLOT_W'(15), 32'sh0ABC_DEF0, -32'sh0123_4567, 32'sh7FFF_0000);
        eval_at(POS_W'(17'h0_4000));
        // all points at the rails: weight rounding can push the sum past full
        // scale, where the outputs saturate
        for (k = 0; k < 4; k++)
            write_point(SLOT_W'(k), COORD_MAX, COORD_MIN, (k % 2 == 0) ? COORD_MAX : COORD_MIN);
        eval_at(POS_W'(12345));
        eval_at(POS_W'(40000));
        eval_at(POS_W'(777));

        // point count extremes: zero, one, full, above full
        set_point_count(CFG_W'(0));
        eval_at(POS_W'(17'h0_8000));
        set_point_count(CFG_W'(1));
        eval_at(POS_W'(17'h0_3000));
        set_point_count(CFG_W'(16));
        eval_at(POS_W'(17'h0_9000));
        set_point_count(CFG_W'(31));
        eval_at(POS_W'(17'h0_C000));

        // --- random phases: new point count, then a mix of writes and evals
        // under each idling pattern in turn ---
        for (phase = 0; phase < 8; phase++)
        begin
            set_point_count(CFG_W'(count_plan[phase]));
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            for (k = 0; k < PHASE_REQS; k++)
            begin
                if ($urandom_range(0, 99) < 40)
                    write_point(SLOT_W'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                                rand_coord());
                else
                    eval_at(rand_position());
            end
        end

        // drain
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests sent, %0d evaluations, %0d results compared",
                 n_sent, n_evals, checked);
        $display("summary: %0d point-count writes (0, 1, 16, 31 included), idling none/in/out/both",
                 n_cfg);
        if (err_count == 0 && pending == 0)
            $display("bezier_curve_evaluator_core_tb: done, clean");
        else
            $display("bezier_curve_evaluator_core_tb: done, errors");
        $finish;
    end

endmodule
